>>> design/tjvt_pkg.sv
// Shared constants, datapath operation codes and controller types for the
// tick jitter variance block. No dependencies.
package tjvt_pkg;

   localparam int WIN_DEPTH = 16;
   localparam int IDX_W     = $clog2(WIN_DEPTH);
   localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
   localparam int DIV_CNT_W = 6;

   localparam logic [63:0] DIFF_LIMIT     = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] SCALE_LIMIT    = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] VAR_LIMIT      = 64'h0000_FFFF_FFFF_FFFF;
   localparam logic [63:0] Q_ONE          = 64'd65536;
   localparam logic [63:0] TRUST_NUM      = 64'h0000_0001_0000_0000;
   localparam logic [63:0] EXPECTED_RESET = 64'd10000000;
   localparam logic [16:0] TRUST_FULL     = 17'd65536;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_VZERO, OP_SUM, OP_MEAN_GO, OP_MEAN_SET,
      OP_SQ_D, OP_SQ_M, OP_SQ_A, OP_VAR_GO, OP_VAR_SET, OP_ESQ_LO,
      OP_ESQ_HI, OP_ESQ_SET, OP_VQ_GO, OP_VQ_SET, OP_TRUST_GO,
      OP_TRUST_FULL, OP_TRUST_SET
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_SUM, S_MEAN_GO, S_MEAN_WAIT, S_SQ_D, S_SQ_M,
      S_SQ_A, S_VAR_GO, S_VAR_WAIT, S_ESQ_LO, S_ESQ_HI, S_ESQ_SET,
      S_VQ_GO, S_VQ_WAIT, S_TRUST_GO, S_TRUST_WAIT, S_RESP
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic first;
      logic small_win;
      logic idx_last;
      logic div_done;
      logic esq_zero;
      logic denom_zero;
   } status_type;

endpackage

>>> design/tjvt_if.sv
// Handshake channels of the tick jitter variance block: tick input,
// result output and expected interval write.
interface tjvt_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] timestamp;
   modport source (output valid, output timestamp, input ready);
   modport sink (input valid, input timestamp, output ready);
endinterface

interface tjvt_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] tick_total;
   logic [63:0] relative_variance;
   logic [16:0] trust_level;
   modport source (output valid, output tick_total, output relative_variance,
                   output trust_level, input ready);
   modport sink (input valid, input tick_total, input relative_variance,
                 input trust_level, output ready);
endinterface

interface tjvt_csr_if;
   logic        valid;
   logic        ready;
   logic [63:0] write_data;
   modport source (output valid, output write_data, input ready);
   modport sink (input valid, input write_data, output ready);
endinterface

>>> design/tjvt_ctrl.sv
// Sequencer for the tick jitter variance block: walks each tick through the
// window passes and the shared divider. Uses tjvt_pkg.
module tjvt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  tjvt_pkg::status_type st,
   output tjvt_pkg::cmd_type   cmd
);
   import tjvt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = st.first ? S_RESP : S_CHECK;
            end
         end
         S_CHECK: begin
            if (st.small_win) begin
               cmd.op   = OP_VZERO;
               state_in = S_TRUST_GO;
            end else begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            cmd.op = OP_SUM;
            if (st.idx_last) state_in = S_MEAN_GO;
         end
         S_MEAN_GO: begin
            cmd.op   = OP_MEAN_GO;
            state_in = S_MEAN_WAIT;
         end
         S_MEAN_WAIT: begin
            if (st.div_done) begin
               cmd.op   = OP_MEAN_SET;
               state_in = S_SQ_D;
            end
         end
         S_SQ_D: begin
            cmd.op   = OP_SQ_D;
            state_in = S_SQ_M;
         end
         S_SQ_M: begin
            cmd.op   = OP_SQ_M;
            state_in = S_SQ_A;
         end
         S_SQ_A: begin
            cmd.op   = OP_SQ_A;
            state_in = st.idx_last ? S_VAR_GO : S_SQ_D;
         end
         S_VAR_GO: begin
            cmd.op   = OP_VAR_GO;
            state_in = S_VAR_WAIT;
         end
         S_VAR_WAIT: begin
            if (st.div_done) begin
               cmd.op   = OP_VAR_SET;
               state_in = S_ESQ_LO;
            end
         end
         S_ESQ_LO: begin
            cmd.op   = OP_ESQ_LO;
            state_in = S_ESQ_HI;
         end
         S_ESQ_HI: begin
            cmd.op   = OP_ESQ_HI;
            state_in = S_ESQ_SET;
         end
         S_ESQ_SET: begin
            cmd.op   = OP_ESQ_SET;
            state_in = S_VQ_GO;
         end
         S_VQ_GO: begin
            if (st.esq_zero) begin
               cmd.op   = OP_VZERO;
               state_in = S_TRUST_GO;
            end else begin
               cmd.op   = OP_VQ_GO;
               state_in = S_VQ_WAIT;
            end
         end
         S_VQ_WAIT: begin
            if (st.div_done) begin
               cmd.op   = OP_VQ_SET;
               state_in = S_TRUST_GO;
            end
         end
         S_TRUST_GO: begin
            if (st.denom_zero) begin
               cmd.op   = OP_TRUST_FULL;
               state_in = S_RESP;
            end else begin
               cmd.op   = OP_TRUST_GO;
               state_in = S_TRUST_WAIT;
            end
         end
         S_TRUST_WAIT: begin
            if (st.div_done) begin
               cmd.op   = OP_TRUST_SET;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

>>> design/tjvt_dp.sv
// Datapath of the tick jitter variance block: deviation window, accumulator,
// 32x32 multiplier and a radix-2 64-bit divider. Uses tjvt_pkg.
module tjvt_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  tjvt_pkg::cmd_type    cmd,
   output tjvt_pkg::status_type st,
   input  logic [63:0]          timestamp,
   input  logic                 csr_we,
   input  logic [63:0]          csr_data,
   output logic [63:0]          tick_total,
   output logic [63:0]          relative_variance,
   output logic [16:0]          trust_level
);
   import tjvt_pkg::*;

   logic [63:0]          exp_ff, exp_in;
   logic [63:0]          prev_ff, prev_in;
   logic                 seen_ff, seen_in;
   logic [63:0]          tick_ff, tick_in;
   logic [63:0]          win_ff [WIN_DEPTH];
   logic                 win_we;
   logic [63:0]          win_wd;
   logic [IDX_W-1:0]     wpos_ff, wpos_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [63:0]          acc_ff, acc_in;
   logic                 neg_ff, neg_in;
   logic [63:0]          mean_ff, mean_in;
   logic [31:0]          d_ff, d_in;
   logic [63:0]          prod_ff, prod_in;
   logic [63:0]          var_ff, var_in;
   logic [63:0]          e_ff, e_in;
   logic [63:0]          esq_ff, esq_in;
   logic [63:0]          variance_ff, variance_in;
   logic [16:0]          trust_ff, trust_in;
   // shared divider: dividend register doubles as quotient
   logic [63:0]          dvd_ff, dvd_in;
   logic [63:0]          dvs_ff, dvs_in;
   logic [63:0]          rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [63:0] win_rd;
   logic [64:0] rem_sh;
   logic        ge;
   logic [63:0] ao, bo, mag, vq, eq;

   assign win_rd = win_ff[idx_ff];

   assign st.first      = !seen_ff;
   assign st.small_win  = (fill_ff < CNT_W'(2)) || (exp_ff == 64'd0);
   assign st.idx_last   = (CNT_W'(idx_ff) == fill_ff - CNT_W'(1));
   assign st.div_done   = done_ff;
   assign st.esq_zero   = (esq_ff == 64'd0);
   assign st.denom_zero = ((variance_ff + Q_ONE) == 64'd0);

   assign tick_total        = tick_ff;
   assign relative_variance = variance_ff;
   assign trust_level       = trust_ff;

   always_comb begin
      exp_in      = csr_we ? csr_data : exp_ff;
      prev_in     = prev_ff;
      seen_in     = seen_ff;
      tick_in     = tick_ff;
      win_we      = 1'b0;
      win_wd      = timestamp - prev_ff - exp_ff;
      wpos_in     = wpos_ff;
      fill_in     = fill_ff;
      idx_in      = idx_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      mean_in     = mean_ff;
      d_in        = d_ff;
      prod_in     = prod_ff;
      var_in      = var_ff;
      e_in        = e_ff;
      esq_in      = esq_ff;
      variance_in = variance_ff;
      trust_in    = trust_ff;
      dvd_in      = dvd_ff;
      dvs_in      = dvs_ff;
      rem_in      = rem_ff;
      dcnt_in     = dcnt_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;

      ao  = win_rd ^ 64'h8000_0000_0000_0000;
      bo  = mean_ff ^ 64'h8000_0000_0000_0000;
      mag = (ao >= bo) ? (ao - bo) : (bo - ao);
      vq  = dvd_ff;
      eq  = exp_ff;
      if (exp_ff > SCALE_LIMIT) begin
         vq = dvd_ff >> 16;
         eq = exp_ff >> 8;
      end

      rem_sh = {rem_ff, dvd_ff[63]};
      ge     = (rem_sh >= {1'b0, dvs_ff});
      if (busy_ff) begin
         rem_in  = ge ? 64'(rem_sh - {1'b0, dvs_ff}) : rem_sh[63:0];
         dvd_in  = {dvd_ff[62:0], ge};
         dcnt_in = dcnt_ff + DIV_CNT_W'(1);
         if (dcnt_ff == {DIV_CNT_W{1'b1}}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end

      case (cmd.op)
         OP_LOAD: begin
            tick_in = tick_ff + 64'd1;
            prev_in = timestamp;
            seen_in = 1'b1;
            acc_in  = 64'd0;
            idx_in  = '0;
            if (seen_ff) begin
               win_we  = 1'b1;
               wpos_in = (wpos_ff == IDX_W'(WIN_DEPTH - 1)) ? '0 : wpos_ff + IDX_W'(1);
               if (fill_ff != CNT_W'(WIN_DEPTH)) fill_in = fill_ff + CNT_W'(1);
            end
         end
         OP_VZERO: variance_in = 64'd0;
         OP_SUM: begin
            acc_in = acc_ff + win_rd;
            idx_in = idx_ff + IDX_W'(1);
         end
         OP_MEAN_GO: begin
            neg_in = acc_ff[63];
            dvd_in = acc_ff[63] ? (64'd0 - acc_ff) : acc_ff;
            dvs_in = 64'(fill_ff);
         end
         OP_MEAN_SET: begin
            mean_in = neg_ff ? (64'd0 - dvd_ff) : dvd_ff;
            acc_in  = 64'd0;
            idx_in  = '0;
         end
         OP_SQ_D: d_in = (mag > DIFF_LIMIT) ? DIFF_LIMIT[31:0] : mag[31:0];
         OP_SQ_M: prod_in = 64'(d_ff) * 64'(d_ff);
         OP_SQ_A: begin
            acc_in = acc_ff + prod_ff;
            idx_in = idx_ff + IDX_W'(1);
         end
         OP_VAR_GO: begin
            dvd_in = acc_ff;
            dvs_in = 64'(fill_ff);
         end
         OP_VAR_SET: begin
            var_in = (vq > VAR_LIMIT) ? VAR_LIMIT : vq;
            e_in   = eq;
         end
         OP_ESQ_LO: prod_in = 64'(e_ff[31:0]) * 64'(e_ff[31:0]);
         OP_ESQ_HI: esq_in = 64'(e_ff[63:32]) * 64'(e_ff[31:0]);
         // e*e mod 2^64 = lo*lo + 2*hi*lo*2^32
         OP_ESQ_SET: esq_in = prod_ff + {esq_ff[30:0], 33'd0};
         OP_VQ_GO: begin
            dvd_in = {var_ff[47:0], 16'd0};
            dvs_in = esq_ff;
         end
         OP_VQ_SET: variance_in = dvd_ff;
         OP_TRUST_GO: begin
            dvd_in = TRUST_NUM;
            dvs_in = variance_ff + Q_ONE;
         end
         OP_TRUST_FULL: trust_in = TRUST_FULL;
         OP_TRUST_SET: trust_in = dvd_ff[16:0];
         default: ;
      endcase

      if (cmd.op == OP_MEAN_GO || cmd.op == OP_VAR_GO || cmd.op == OP_VQ_GO ||
          cmd.op == OP_TRUST_GO) begin
         rem_in  = 64'd0;
         dcnt_in = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff      <= EXPECTED_RESET;
         seen_ff     <= 1'b0;
         tick_ff     <= 64'd0;
         prev_ff     <= 64'd0;
         wpos_ff     <= '0;
         fill_ff     <= '0;
         variance_ff <= 64'd0;
         trust_ff    <= TRUST_FULL;
         busy_ff     <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         exp_ff      <= exp_in;
         seen_ff     <= seen_in;
         tick_ff     <= tick_in;
         prev_ff     <= prev_in;
         wpos_ff     <= wpos_in;
         fill_ff     <= fill_in;
         variance_ff <= variance_in;
         trust_ff    <= trust_in;
         busy_ff     <= busy_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (win_we) win_ff[wpos_ff] <= win_wd;
      idx_ff  <= idx_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      mean_ff <= mean_in;
      d_ff    <= d_in;
      prod_ff <= prod_in;
      var_ff  <= var_in;
      e_ff    <= e_in;
      esq_ff  <= esq_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      dcnt_ff <= dcnt_in;
   end

endmodule

>>> design/tick_jitter_variance_trust_unit.sv
// Heartbeat jitter monitor. Each tick item gives one result item holding the
// tick count, the window variance relative to the expected interval squared
// in Q48.16 and the trust level in Q1.16. The first tick after reset goes
// straight to the result handshake. Later ticks run one at a time through a
// sequencer: a sum pass over the filled window entries (up to 16), a squares
// pass through the multiplier, and up to four passes of the shared radix-2
// divider, then the result handshake; a window of fewer than two entries or
// a zero expected interval skips to the trust division with zero variance.
// The expected interval register takes a write in any cycle.
// Depends on tjvt_pkg, tjvt_if, tjvt_ctrl and tjvt_dp.
module tick_jitter_variance_trust_unit (
   input logic       clock,
   input logic       reset,
   tjvt_req_if.sink  req_ch,
   tjvt_rsp_if.source rsp_ch,
   tjvt_csr_if.sink  csr_ch
);
   import tjvt_pkg::*;

   cmd_type    cmd;
   status_type st;

   assign csr_ch.ready = 1'b1;

   tjvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   tjvt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .timestamp         (req_ch.timestamp),
      .csr_we            (csr_ch.valid),
      .csr_data          (csr_ch.write_data),
      .tick_total        (rsp_ch.tick_total),
      .relative_variance (rsp_ch.relative_variance),
      .trust_level       (rsp_ch.trust_level)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("input taken while a result is pending");

   a_trust_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.trust_level <= TRUST_FULL))
      else $error("trust level above full scale");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("second item accepted before result");

endmodule
